// File: hdl/blm_pkg.sv
// ============================================================================
// blm_pkg: shared types and constants for the Lucas binomial block
// Widths of the data path and the request and response bundles of the
// shared multi-cycle divider.
// ============================================================================
package blm_pkg;

    localparam int ARG_W   = 32;             // width of one argument
    localparam int RES_W   = 16;             // width of residues and the modulus
    localparam int DIV_CNT_W = $clog2(ARG_W); // divider step counter width

    typedef struct packed {
        logic             start;
        logic [ARG_W-1:0] dividend;
        logic [RES_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ARG_W-1:0] quotient;
        logic [RES_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: hdl/blm_ram.sv
// ============================================================================
// blm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module blm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/blm_divider.sv
// ============================================================================
// blm_divider: iterative restoring divider
// Divides a 32-bit value by a 16-bit divisor, one quotient bit per cycle.
// ============================================================================
module blm_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  blm_pkg::div_req_t req,
    output blm_pkg::div_rsp_t rsp
);

    logic [blm_pkg::ARG_W-1:0]     dq_reg;
    logic [blm_pkg::RES_W-1:0]     rem_reg;
    logic [blm_pkg::RES_W-1:0]     dvs_reg;
    logic [blm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [blm_pkg::RES_W:0]       rem_sh;
    logic                          fits;
    logic [blm_pkg::RES_W:0]       rem_new;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign rem_sh  = {rem_reg, dq_reg[blm_pkg::ARG_W-1]};
    assign fits    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_new = fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == blm_pkg::DIV_CNT_W'(blm_pkg::ARG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[blm_pkg::ARG_W-2:0], fits};
            rem_reg <= rem_new[blm_pkg::RES_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: hdl/binomial_mod_prime_lucas.sv
// ============================================================================
// binomial_mod_prime_lucas: binomial coefficient modulo a prime
// Computes C(n, k) mod p with Lucas's theorem over a factorial table in RAM.
// ============================================================================
// Usage notes.
// The input channel (s_tvalid/s_tready/s_tdata) carries one query per
// transfer: n in the low 32 bits, k in the high 32 bits. The result channel
// (m_tvalid/m_tready/m_tdata) returns one 16-bit residue per query, in order.
// The modulus p is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, as the block does not enforce this. Every
// write invalidates the factorial table. One query is worked on at a time.
// All modular arithmetic goes through one shared divider. Each base-p digit
// costs two divisions, three table reads, and two Fermat inversions of up to
// 2*bitlen(p) products each; the base-p digits of max(n, k) are worked
// through in turn, stopping early once the result is 0. The first query
// after reset or after a modulus write first builds the table. A modulus
// outside 2..depth-1 returns 0.
// Reset returns the modulus to 2 and marks the table invalid. A finished
// result waits in the output register while the receiver stalls; the next
// query is taken meanwhile and held back only when its own result is ready.
// ============================================================================
module binomial_mod_prime_lucas #(
    parameter int TABLE_DEPTH = 65536,
    parameter int VALUE_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: prime_modulus
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] top_count, [63:32] choose_count
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] binom_residue
);

    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int ARG_W    = blm_pkg::ARG_W;
    localparam int RES_W    = blm_pkg::RES_W;
    localparam int MASK_W   = (VALUE_BITS < ARG_W) ? VALUE_BITS : ARG_W;
    localparam logic [ARG_W-1:0] ARG_MASK = {ARG_W{1'b1}} >> (ARG_W - MASK_W);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_BINIT    = 5'd1;
    localparam logic [4:0] S_BUILD    = 5'd2;
    localparam logic [4:0] S_DIGIT    = 5'd3;
    localparam logic [4:0] S_DIVN     = 5'd4;
    localparam logic [4:0] S_DIVK     = 5'd5;
    localparam logic [4:0] S_CHK      = 5'd6;
    localparam logic [4:0] S_RDA      = 5'd7;
    localparam logic [4:0] S_RDB      = 5'd8;
    localparam logic [4:0] S_RDC      = 5'd9;
    localparam logic [4:0] S_RDD      = 5'd10;
    localparam logic [4:0] S_MUL_FA   = 5'd11;
    localparam logic [4:0] S_POW_INIT = 5'd12;
    localparam logic [4:0] S_POW_LOOP = 5'd13;
    localparam logic [4:0] S_POW_SQR  = 5'd14;
    localparam logic [4:0] S_MUL_T    = 5'd15;
    localparam logic [4:0] S_NEXT     = 5'd16;
    localparam logic [4:0] S_WAIT     = 5'd17;
    localparam logic [4:0] S_OUT      = 5'd18;

    // Where a divider result goes when it arrives.
    localparam logic [2:0] D_FVAL = 3'd0;
    localparam logic [2:0] D_QN   = 3'd1;
    localparam logic [2:0] D_QK   = 3'd2;
    localparam logic [2:0] D_R_FA = 3'd3;
    localparam logic [2:0] D_ACC  = 3'd4;
    localparam logic [2:0] D_BASE = 3'd5;
    localparam logic [2:0] D_R_T  = 3'd6;

    logic [4:0]       state_reg;
    logic [2:0]       dest_reg;
    logic [RES_W-1:0] prime_reg;
    logic             ready_reg;
    logic             m_valid_reg;
    logic [RES_W-1:0] m_data_reg;
    logic             psel_reg;

    logic [ARG_W-1:0] n_reg, k_reg, qn_reg, qk_reg;
    logic [RES_W-1:0] a_reg, b_reg, fa_reg, fb_reg, fc_reg;
    logic [RES_W-1:0] r_reg, acc_reg, base_reg, e_reg, fval_reg, i_reg;

    blm_pkg::div_req_t div_req;
    blm_pkg::div_rsp_t div_rsp;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [RES_W-1:0]   mem_wdata, mem_rdata;
    logic [RES_W-1:0]   mul_a, mul_b;
    logic               use_mul;
    logic [ARG_W-1:0]   product;
    logic [ARG_W-1:0]   div_num;
    logic               bad_mod;
    logic [RES_W-1:0]   pow_in;
    logic               s_fire;
    logic               out_free;

    // Moduli below two or at/above the table depth give the error value 0.
    assign bad_mod  = (prime_reg < RES_W'(2)) || (32'(prime_reg) >= 32'(TABLE_DEPTH));
    assign pow_in   = psel_reg ? fc_reg : fb_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign product  = ARG_W'(mul_a) * ARG_W'(mul_b);

    // The table is written only while it is built and read only afterwards,
    // so no read ever overlaps a write to the same entry.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        use_mul   = 1'b0;
        div_num   = n_reg;
        div_req.start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(i_reg);
        mem_wdata = div_rsp.remainder;
        mem_raddr = '0;
        case (state_reg)
            S_BINIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = RES_W'(1);
            end
            S_BUILD: begin
                mul_a   = fval_reg;
                mul_b   = i_reg;
                use_mul = 1'b1;
                div_req.start = (i_reg != prime_reg);
            end
            S_DIVN: begin
                div_num = n_reg;
                div_req.start = 1'b1;
            end
            S_DIVK: begin
                div_num = k_reg;
                div_req.start = 1'b1;
            end
            S_RDA: mem_raddr = ADDR_W'(a_reg);
            S_RDB: mem_raddr = ADDR_W'(b_reg);
            S_RDC: mem_raddr = ADDR_W'(a_reg - b_reg);
            S_MUL_FA: begin
                mul_a   = r_reg;
                mul_b   = fa_reg;
                use_mul = 1'b1;
                div_req.start = 1'b1;
            end
            S_POW_LOOP: begin
                mul_a   = acc_reg;
                mul_b   = base_reg;
                use_mul = 1'b1;
                div_req.start = (e_reg != '0) && e_reg[0];
            end
            S_POW_SQR: begin
                mul_a   = base_reg;
                mul_b   = base_reg;
                use_mul = 1'b1;
                div_req.start = 1'b1;
            end
            S_MUL_T: begin
                mul_a   = r_reg;
                mul_b   = acc_reg;
                use_mul = 1'b1;
                div_req.start = 1'b1;
            end
            S_WAIT: mem_we = div_rsp.done && (dest_reg == D_FVAL);
            default: begin
            end
        endcase
        div_req.dividend = use_mul ? product : div_num;
        div_req.divisor  = prime_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            prime_reg   <= RES_W'(2);
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (bad_mod) begin
                            state_reg <= S_OUT;
                        end else if (ready_reg) begin
                            state_reg <= S_DIGIT;
                        end else begin
                            state_reg <= S_BINIT;
                        end
                    end
                end
                S_BINIT: state_reg <= S_BUILD;
                S_BUILD: begin
                    if (i_reg == prime_reg) begin
                        ready_reg <= 1'b1;
                        state_reg <= S_DIGIT;
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_DIGIT: begin
                    if (n_reg == '0 && k_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN:     state_reg <= S_WAIT;
                S_DIVK:     state_reg <= S_WAIT;
                S_CHK:      state_reg <= (b_reg > a_reg) ? S_OUT : S_RDA;
                S_RDA:      state_reg <= S_RDB;
                S_RDB:      state_reg <= S_RDC;
                S_RDC:      state_reg <= S_RDD;
                S_RDD:      state_reg <= S_MUL_FA;
                S_MUL_FA:   state_reg <= S_WAIT;
                S_POW_INIT: begin
                    if (prime_reg == RES_W'(2) || pow_in == '0) begin
                        state_reg <= S_MUL_T;
                    end else begin
                        state_reg <= S_POW_LOOP;
                    end
                end
                S_POW_LOOP: begin
                    if (e_reg == '0) begin
                        state_reg <= S_MUL_T;
                    end else if (e_reg[0]) begin
                        state_reg <= S_WAIT;
                    end else begin
                        state_reg <= S_POW_SQR;
                    end
                end
                S_POW_SQR:  state_reg <= S_WAIT;
                S_MUL_T:    state_reg <= S_WAIT;
                S_NEXT:     state_reg <= (r_reg == '0) ? S_OUT : S_DIGIT;
                S_WAIT: begin
                    if (div_rsp.done) begin
                        case (dest_reg)
                            D_FVAL: state_reg <= S_BUILD;
                            D_QN:   state_reg <= S_DIVK;
                            D_QK:   state_reg <= S_CHK;
                            D_R_FA: state_reg <= S_POW_INIT;
                            D_ACC:  state_reg <= S_POW_SQR;
                            D_BASE: state_reg <= S_POW_LOOP;
                            D_R_T:  state_reg <= psel_reg ? S_NEXT : S_POW_INIT;
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // A modulus write invalidates the table.
            if (cfg_wen) begin
                prime_reg <= cfg_wdata;
                ready_reg <= 1'b0;
            end
        end
    end

    // Data path registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                n_reg <= s_tdata[31:0] & ARG_MASK;
                k_reg <= s_tdata[63:32] & ARG_MASK;
                r_reg <= bad_mod ? '0 : RES_W'(1);
            end
            S_BINIT: begin
                fval_reg <= RES_W'(1);
                i_reg    <= RES_W'(1);
            end
            S_BUILD:   dest_reg <= D_FVAL;
            S_DIVN:    dest_reg <= D_QN;
            S_DIVK:    dest_reg <= D_QK;
            S_CHK: begin
                if (b_reg > a_reg) begin
                    r_reg <= '0;
                end
            end
            S_RDB:     fa_reg <= mem_rdata;
            S_RDC:     fb_reg <= mem_rdata;
            S_RDD:     fc_reg <= mem_rdata;
            S_MUL_FA: begin
                dest_reg <= D_R_FA;
                psel_reg <= 1'b0;
            end
            S_POW_INIT: begin
                base_reg <= pow_in;
                e_reg    <= prime_reg - RES_W'(2);
                // Exponent zero gives 1; a zero base gives 0.
                if (prime_reg == RES_W'(2)) begin
                    acc_reg <= RES_W'(1);
                end else if (pow_in == '0) begin
                    acc_reg <= '0;
                end else begin
                    acc_reg <= RES_W'(1);
                end
            end
            S_POW_LOOP: dest_reg <= D_ACC;
            S_POW_SQR:  dest_reg <= D_BASE;
            S_MUL_T:    dest_reg <= D_R_T;
            S_NEXT: begin
                n_reg <= qn_reg;
                k_reg <= qk_reg;
            end
            S_WAIT: begin
                if (div_rsp.done) begin
                    case (dest_reg)
                        D_FVAL: begin
                            fval_reg <= div_rsp.remainder;
                            i_reg    <= i_reg + RES_W'(1);
                        end
                        D_QN: begin
                            qn_reg <= div_rsp.quotient;
                            a_reg  <= div_rsp.remainder;
                        end
                        D_QK: begin
                            qk_reg <= div_rsp.quotient;
                            b_reg  <= div_rsp.remainder;
                        end
                        D_R_FA: r_reg <= div_rsp.remainder;
                        D_ACC:  acc_reg <= div_rsp.remainder;
                        D_BASE: begin
                            base_reg <= div_rsp.remainder;
                            e_reg    <= e_reg >> 1;
                        end
                        D_R_T: begin
                            r_reg    <= div_rsp.remainder;
                            psel_reg <= 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_data_reg <= r_reg;
                end
            end
            default: begin
            end
        endcase
    end

    blm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    blm_ram #(
        .WIDTH (RES_W),
        .DEPTH (TABLE_DEPTH)
    ) u_fact_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
